### sv/assert_macros.svh
// Assertion helpers: clk and arst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/md5sh_pkg.sv
`default_nettype none
package md5sh_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	typedef struct packed {
		logic start;
		logic reinit;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic logic [31:0] step_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	// Message word used by step i.
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		logic [3:0] n;
		n = i[3:0];
		case (i[5:4])
			2'd0: g = n;
			2'd1: g = 4'((n << 2) + n + 4'd1);
			2'd2: g = 4'((n << 1) + n + 4'd5);
			2'd3: g = 4'((n << 3) - n);
			default: g = n;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] w;
		w = {32'h0, x} << s;
		return w[63:32] | w[31:0];
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage
`default_nettype wire

### sv/md5sh_if.sv
`default_nettype none
interface md5sh_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic end_of_message;
	modport source(output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md5sh_out_if;
	logic valid;
	logic ready;
	logic [63:0] digest_half;
	logic half_index;
	logic last_half;
	modport source(output valid, digest_half, half_index, last_half, input ready);
	modport sink(input valid, digest_half, half_index, last_half, output ready);
endinterface
`default_nettype wire

### sv/md5sh_buf.sv
`default_nettype none
module md5sh_buf import md5sh_pkg::*; (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [5:0] wr_addr,
	input wire logic [7:0] wr_data,
	input wire logic [3:0] rd_addr,
	output logic [31:0] rd_data_s1
);
	// 16 little-endian words; bytes land in their lane.
	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end
endmodule
`default_nettype wire

### sv/md5sh_core.sv
`default_nettype none
module md5sh_core import md5sh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire core_ctl_t ctl,
	output core_stat_t stat,
	output logic [3:0] rd_addr,
	input wire logic [31:0] rd_data_s1,
	output logic [3:0][31:0] chain
);
	typedef enum logic [1:0] {C_IDLE, C_PRIME, C_RUN, C_ADD} cstate_t;

	cstate_t st_q;
	logic [5:0] step_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [3:0][31:0] chain_q;
	logic done_q;
	logic [31:0] f, t, b_new;

	always_comb begin
		case (step_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		t = a_q + f + rd_data_s1 + step_const(step_q);
		b_new = b_q + rotl32(t, rot_amount(step_q));
	end

	// Fetch one step ahead to cover the read latency.
	assign rd_addr = (st_q == C_PRIME) ? msg_index(6'd0) : msg_index(6'(step_q + 6'd1));
	assign chain = chain_q;
	assign stat.busy = (st_q != C_IDLE) || done_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
			chain_q <= {IV_D, IV_C, IV_B, IV_A};
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (ctl.reinit) begin
						chain_q <= {IV_D, IV_C, IV_B, IV_A};
					end
					if (ctl.start) begin
						a_q <= chain_q[0];
						b_q <= chain_q[1];
						c_q <= chain_q[2];
						d_q <= chain_q[3];
						step_q <= '0;
						st_q <= C_PRIME;
					end
				end
				C_PRIME: st_q <= C_RUN;
				C_RUN: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= b_new;
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						st_q <= C_ADD;
					end
				end
				C_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					done_q <= 1'b1;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/md5_stream_hasher_unit.sv
// MD5 hasher, at most one message byte per request. A byte request that does not fill the
// 64-byte block is taken without holding the input; a request that fills it holds the input
// while the compression core runs its 64 steps, one per cycle, against the
// block memory's single read port. An end-of-message request then writes the
// padding one byte per cycle up to the end of the current block and compresses
// it; when the length does not fit in that block, a second block of padding and
// length follows with another compression. The digest comes out as two 64-bit
// halves, first digest byte in bits 63..56. Input is refused until both halves
// are taken; after that the unit starts the next message from the initial state.
`default_nettype none
`include "assert_macros.svh"
module md5_stream_hasher_unit import md5sh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	md5sh_in_if.sink msg,
	md5sh_out_if.source dig
);
	typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_OUT} state_t;

	state_t st_q;
	logic [5:0] fill_q;
	logic [63:0] count_q;
	logic fin_q, mark_q, len_q, final_q;
	logic out_valid_q, half_q;
	logic [63:0] half_data_q;

	core_ctl_t core_ctl;
	core_stat_t core_stat;
	logic [3:0] rd_addr;
	logic [31:0] rd_data_s1;
	logic [3:0][31:0] chain;

	logic wr_en;
	logic [7:0] wr_data, pad_byte;
	logic len_now, in_acc, out_acc;

	assign in_acc = msg.valid && msg.ready;
	assign out_acc = dig.valid && dig.ready;
	assign msg.ready = (st_q == S_IDLE);
	assign dig.valid = out_valid_q;
	assign dig.digest_half = half_data_q;
	assign dig.half_index = half_q;
	assign dig.last_half = half_q;

	assign len_now = len_q || (mark_q && (fill_q == LEN_OFFSET));
	always_comb begin
		if (len_now) begin
			pad_byte = count_q[{fill_q[2:0], 3'b000} +: 8];
		end else if (mark_q) begin
			pad_byte = 8'h00;
		end else begin
			pad_byte = PAD_MARK;
		end
	end

	assign wr_en = (in_acc && msg.has_byte) || (st_q == S_PAD);
	assign wr_data = (st_q == S_PAD) ? pad_byte : msg.data_byte;

	always_comb begin
		core_ctl.start = wr_en && (fill_q == 6'd63);
		core_ctl.reinit = out_acc && half_q;
	end

	md5sh_buf u_buf (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(fill_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	md5sh_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(core_ctl),
		.stat(core_stat),
		.rd_addr(rd_addr),
		.rd_data_s1(rd_data_s1),
		.chain(chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fill_q <= '0;
			count_q <= '0;
			fin_q <= 1'b0;
			mark_q <= 1'b0;
			len_q <= 1'b0;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (msg.has_byte) begin
							count_q <= count_q + 64'd8;
						end
						fin_q <= msg.end_of_message;
						if (msg.has_byte && fill_q == 6'd63) begin
							st_q <= S_COMP;
						end else if (msg.end_of_message) begin
							st_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					mark_q <= 1'b1;
					len_q <= len_now;
					if (fill_q == 6'd63) begin
						final_q <= len_now;
						st_q <= S_COMP;
					end
				end
				S_COMP: begin
					if (core_stat.done) begin
						if (final_q) begin
							half_data_q <= {bswap32(chain[0]), bswap32(chain[1])};
							half_q <= 1'b0;
							out_valid_q <= 1'b1;
							st_q <= S_OUT;
						end else if (fin_q) begin
							st_q <= S_PAD;
						end else begin
							st_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (!half_q) begin
							half_data_q <= {bswap32(chain[2]), bswap32(chain[3])};
							half_q <= 1'b1;
						end else begin
							out_valid_q <= 1'b0;
							half_q <= 1'b0;
							fill_q <= '0;
							count_q <= '0;
							fin_q <= 1'b0;
							mark_q <= 1'b0;
							len_q <= 1'b0;
							final_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_in_while_out, msg.ready, !dig.valid, "input open while digest pending")
	`ASSERT_IMPL(a_no_wr_while_busy, wr_en, !core_stat.busy, "block write during compression")
	`ASSERT_NEXT(a_second_half, out_acc && !half_q, dig.valid && dig.half_index, "second half missing")
	`ASSERT_IMPL(a_done_in_comp, core_stat.done, st_q == S_COMP, "compression done out of sequence")
endmodule
`default_nettype wire

### sim/md5_stream_hasher_checker.sv
`default_nettype none
module md5_stream_hasher_checker import md5sh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	md5sh_in_if.sink msg,
	md5sh_out_if.sink dig,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] digest_half;
		logic half_index;
		logic last_half;
	} digest_half_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
		32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
		32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
		32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
		32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
		32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic [31:0] chain [4];
	logic [7:0] block [64];
	logic [63:0] msg_bits;
	logic [5:0] fill;
	digest_half_t pending_digest[$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic restart_message();
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		msg_bits = '0;
		fill = '0;
	endtask

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 16; i++)
			w[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (b & d) | (c & ~d); g = 5 * i + 1; end
				2: begin f = b ^ c ^ d; g = 3 * i + 5; end
				default: begin f = c ^ (b | ~d); g = 7 * i; end
			endcase
			t = a + f + w[g % 16] + ROUND_K[i];
			a = d; d = c; c = b;
			b = b + rol(t, SHIFTS[(i / 16) * 4 + i % 4]);
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endtask

	task automatic absorb(input logic [7:0] v);
		block[fill] = v;
		fill = fill + 6'd1;
		if (fill == 6'd0)
			compress();
	endtask

	task automatic predict_request(input logic [7:0] v, input logic has, input logic fin);
		logic [63:0] len, half;
		int k;
		if (has) begin
			msg_bits += 64'd8;
			absorb(v);
		end
		if (fin) begin
			len = msg_bits;
			absorb(PAD_MARK);
			while (fill != LEN_OFFSET)
				absorb(8'h00);
			for (int i = 0; i < 8; i++)
				absorb(len[8*i +: 8]);
			for (int h = 0; h < 2; h++) begin
				half = '0;
				for (int i = 0; i < 8; i++) begin
					k = 8 * h + i;
					half = {half[55:0], chain[k / 4][8*(k % 4) +: 8]};
				end
				pending_digest.push_back('{half, 1'(h), 1'(h)});
			end
			restart_message();
		end
	endtask

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic bit idle();
		return pending_digest.size() == 0;
	endfunction

	initial begin
		fail_count = 0;
		restart_message();
	end

	always @(posedge clk) begin
		digest_half_t exp_h;
		if (arst_n) begin
			if (dig.valid && dig.ready) begin
				if (pending_digest.size() == 0)
					report($sformatf("unexpected digest half %h", dig.digest_half));
				else begin
					exp_h = pending_digest.pop_front();
					if (dig.digest_half !== exp_h.digest_half)
						report($sformatf("digest_half %h, want %h",
							dig.digest_half, exp_h.digest_half));
					if (dig.half_index !== exp_h.half_index)
						report($sformatf("half_index %b, want %b",
							dig.half_index, exp_h.half_index));
					if (dig.last_half !== exp_h.last_half)
						report($sformatf("last_half %b, want %b",
							dig.last_half, exp_h.last_half));
				end
			end
			if (msg.valid && msg.ready)
				predict_request(msg.data_byte, msg.has_byte, msg.end_of_message);
		end
	end
endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int unsigned fail_count;
	int unsigned hold_cycles;

	md5sh_in_if msg ();
	md5sh_out_if dig ();

	md5_stream_hasher_unit u_dut (.clk(clk), .arst_n(arst_n), .msg(msg), .dig(dig));
	md5_stream_hasher_checker u_checker (
		.clk(clk), .arst_n(arst_n), .msg(msg), .dig(dig), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("md5_stream_hasher_unit regression: fail");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Present one request, hold it until taken; drop valid only across a gap.
	task automatic send(input logic [7:0] v, input logic has, input logic fin);
		int g;
		g = gap_len();
		if (g > 0) begin
			msg.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		msg.valid <= 1'b1;
		msg.data_byte <= v;
		msg.has_byte <= has;
		msg.end_of_message <= fin;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
	endtask

	task automatic send_message(input int len, input bit byte_on_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send(8'($urandom), 1'b0, 1'b0);
			send(8'($urandom), 1'b1, 1'b0);
		end
		send(8'($urandom), byte_on_end, 1'b1);
	endtask

	// Receiver: random stalls, plus one long hold-off after reset while the input is refused.
	initial begin
		dig.ready = 1'b0;
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		hold_cycles = 0;
		while (hold_cycles < 3000) begin
			@(posedge clk);
			hold_cycles++;
		end
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				dig.ready <= 1'b0;
				repeat ($urandom_range(10, 80)) @(posedge clk);
			end else begin
				dig.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
			end
			@(posedge clk);
		end
	end

	initial begin
		int len, budget;
		msg.valid = 1'b0;
		msg.data_byte = '0;
		msg.has_byte = 1'b0;
		msg.end_of_message = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, idle item, extremes, block boundaries.
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b0, 1'b0);
		send(8'hff, 1'b1, 1'b1);
		send(8'h00, 1'b1, 1'b1);
		send(8'haa, 1'b1, 1'b0);
		send(8'h55, 1'b1, 1'b1);
		send_message(54, 1'b1);
		send_message(56, 1'b0);
		send_message(63, 1'b1);

		budget = 1400;
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(60, 130);
				1, 2: len = $urandom_range(50, 66);
				default: len = $urandom_range(0, 30);
			endcase
			send_message(len, 1'($urandom));
			budget -= len + 1;
		end
		msg.valid <= 1'b0;

		repeat (200) @(posedge clk);
		while (!u_checker.idle()) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("md5_stream_hasher_unit regression: pass");
		else
			$display("md5_stream_hasher_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/md5sh_pkg.sv
sv/md5sh_if.sv
sv/md5sh_buf.sv
sv/md5sh_core.sv
sv/md5_stream_hasher_unit.sv
sim/md5_stream_hasher_checker.sv
sim/testbench.sv
